[sv/segfl_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, control word types and the microprogram of the free-list allocator.
package segfl_pkg;

    localparam int ADDR_W = 12;
    localparam int SIZE_W = 7;
    localparam int DATA_W = 32;
    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int CMP_W = 21;
    localparam int STEP_W = 4;

    localparam int DEF_MEM_WORDS = 4096;
    localparam int DEF_MAX_SIZE = 64;
    localparam int DEF_WORD_BITS = 32;

    localparam logic [OP_W-1:0] OP_FREE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    localparam logic [ST_W-1:0] ST_OK  = 2'd0;
    localparam logic [ST_W-1:0] ST_UAF = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD = 2'd2;

    localparam logic [STEP_W-1:0] S_CLR  = 4'd0;
    localparam logic [STEP_W-1:0] S_IDLE = 4'd1;
    localparam logic [STEP_W-1:0] S_F0   = 4'd2;
    localparam logic [STEP_W-1:0] S_F1   = 4'd3;
    localparam logic [STEP_W-1:0] S_A0   = 4'd4;
    localparam logic [STEP_W-1:0] S_A1   = 4'd5;
    localparam logic [STEP_W-1:0] S_A2   = 4'd6;
    localparam logic [STEP_W-1:0] S_A3   = 4'd7;
    localparam logic [STEP_W-1:0] S_A4   = 4'd8;
    localparam logic [STEP_W-1:0] S_A5   = 4'd9;
    localparam logic [STEP_W-1:0] S_W0   = 4'd10;
    localparam logic [STEP_W-1:0] S_R0   = 4'd11;
    localparam logic [STEP_W-1:0] S_R1   = 4'd12;
    localparam logic [STEP_W-1:0] S_END  = 4'd13;

    typedef enum logic [1:0] {
        WS_ZERO  = 2'b00,
        WS_WDATA = 2'b01,
        WS_LINK  = 2'b10
    } wsrc_t;

    typedef enum logic [1:0] {
        AS_BLK     = 2'b00,
        AS_BLK_CNT = 2'b01,
        AS_CLR     = 2'b10
    } asrc_t;

    typedef enum logic [1:0] {
        HS_ZERO = 2'b00,
        HS_BLK  = 2'b01,
        HS_LINK = 2'b10
    } hsrc_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_IF_MORE  = 3'd2,
        C_IF_LAST  = 3'd3,
        C_IF_HEAD0 = 3'd4,
        C_IF_CLR   = 3'd5,
        C_ACCEPT   = 3'd6,
        C_EMIT     = 3'd7
    } cond_t;

    typedef struct packed {
        logic              mem_we;
        logic              mem_re;
        logic              chk;
        wsrc_t             wsrc;
        asrc_t             asrc;
        logic              head_re;
        logic              head_we;
        hsrc_t             hsrc;
        logic              cnt_inc;
        logic              clr_inc;
        logic              blk_ld;
        logic              set_hit;
        logic              rd_ld;
        logic              emit;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '0;
        case (step)
            S_CLR:
            begin
                c.mem_we  = 1'b1;
                c.asrc    = AS_CLR;
                c.head_we = 1'b1;
                c.clr_inc = 1'b1;
                c.cond    = C_IF_CLR;
                c.target  = S_CLR;
            end
            S_IDLE:
            begin
                c.cond = C_ACCEPT;
            end
            S_F0:
            begin
                c.head_re = 1'b1;
                c.mem_we  = 1'b1;
                c.asrc    = AS_BLK_CNT;
                c.cnt_inc = 1'b1;
                c.cond    = C_IF_MORE;
                c.target  = S_F0;
            end
            S_F1:
            begin
                c.mem_we  = 1'b1;
                c.wsrc    = WS_LINK;
                c.head_we = 1'b1;
                c.hsrc    = HS_BLK;
                c.cond    = C_JUMP;
                c.target  = S_END;
            end
            S_A0:
            begin
                c.head_re = 1'b1;
            end
            S_A1:
            begin
                c.blk_ld = 1'b1;
                c.cond   = C_IF_HEAD0;
                c.target = S_END;
            end
            S_A2:
            begin
                c.mem_re  = 1'b1;
                c.set_hit = 1'b1;
            end
            S_A3:
            begin
                c.head_we = 1'b1;
                c.hsrc    = HS_LINK;
                c.mem_we  = 1'b1;
                c.cnt_inc = 1'b1;
                c.cond    = C_IF_LAST;
                c.target  = S_END;
            end
            S_A4:
            begin
                c.mem_re  = 1'b1;
                c.chk     = 1'b1;
                c.asrc    = AS_BLK_CNT;
                c.cnt_inc = 1'b1;
                c.cond    = C_IF_MORE;
                c.target  = S_A4;
            end
            S_A5:
            begin
                c.cond   = C_JUMP;
                c.target = S_END;
            end
            S_W0:
            begin
                c.mem_we = 1'b1;
                c.wsrc   = WS_WDATA;
                c.cond   = C_JUMP;
                c.target = S_END;
            end
            S_R0:
            begin
                c.mem_re = 1'b1;
            end
            S_R1:
            begin
                c.rd_ld  = 1'b1;
                c.cond   = C_JUMP;
                c.target = S_END;
            end
            S_END:
            begin
                c.emit   = 1'b1;
                c.cond   = C_EMIT;
                c.target = S_IDLE;
            end
            default:
            begin
                c.cond   = C_JUMP;
                c.target = S_IDLE;
            end
        endcase
        return c;
    endfunction

endpackage

[sv/segregated_free_list_allocator.sv]
`timescale 1ns / 1ps
// Top level of the segregated free-list allocator: microprogram sequencer, word memory, list heads.
// The block holds MEM_WORDS words and one free list per block size from 1 to MAX_SIZE, and it
// answers every input beat with exactly one result beat. A short microprogram in a read-only
// table steps a single-port word memory and a list-head memory, one word access per cycle, and
// the input stays stalled from one accepted beat until its result beat has been emitted, so no
// new item is taken before the last is through (a waiting result that is stalled holds this
// up). After reset a clearing pass zeroes the memory and the list heads, one entry per cycle
// over the larger of MEM_WORDS and MAX_SIZE entries, while the input is stalled. An allocate
// that finds a nonzero word past the link word of the popped block reports status 1 but still
// returns the block; a link that points past the memory reads as zero.
module segregated_free_list_allocator #(
    parameter int MEM_WORDS = segfl_pkg::DEF_MEM_WORDS,
    parameter int MAX_SIZE  = segfl_pkg::DEF_MAX_SIZE,
    parameter int WORD_BITS = segfl_pkg::DEF_WORD_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [segfl_pkg::OP_W-1:0]    opcode,
    input  logic [segfl_pkg::ADDR_W-1:0]  address,
    input  logic [segfl_pkg::SIZE_W-1:0]  size,
    input  logic [segfl_pkg::DATA_W-1:0]  write_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [segfl_pkg::ADDR_W-1:0]  result_address,
    output logic                          hit,
    output logic [segfl_pkg::DATA_W-1:0]  read_data,
    output logic [segfl_pkg::ST_W-1:0]    status
);

    localparam int ADDR_W = segfl_pkg::ADDR_W;
    localparam int SIZE_W = segfl_pkg::SIZE_W;
    localparam int DATA_W = segfl_pkg::DATA_W;
    localparam int ST_W = segfl_pkg::ST_W;
    localparam int CMP_W = segfl_pkg::CMP_W;
    localparam int STEP_W = segfl_pkg::STEP_W;
    localparam int AW = $clog2(MEM_WORDS);
    localparam int HW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CLR_LEN = (MEM_WORDS > MAX_SIZE) ? MEM_WORDS : MAX_SIZE;
    localparam int CLRW = $clog2(CLR_LEN);
    localparam int EW = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
    localparam logic [CLRW-1:0] CLR_LAST = CLRW'(CLR_LEN - 1);
    localparam logic [CLRW:0] CLR_HEADS = (CLRW + 1)'(MAX_SIZE);
    localparam logic [EW-1:0] MEM_LIM_E = EW'(MEM_WORDS);
    localparam logic [CMP_W-1:0] MEM_LIM_C = CMP_W'(MEM_WORDS);
    localparam logic [CMP_W-1:0] MAX_SIZE_C = CMP_W'(MAX_SIZE);

    logic [WORD_BITS-1:0] mem [MEM_WORDS];
    logic [ADDR_W-1:0] head_mem [MAX_SIZE];

    segfl_pkg::ctrl_t ctrl;

    logic [STEP_W-1:0] upc_reg, upc_next;
    logic [CLRW-1:0] clr_reg, clr_next;
    logic [SIZE_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0] blk_reg, blk_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [DATA_W-1:0] wdata_reg, wdata_next;
    logic [ST_W-1:0] status_reg, status_next;
    logic hit_reg, hit_next;
    logic [DATA_W-1:0] rdata_reg, rdata_next;
    logic out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;
    logic out_hit_reg, out_hit_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic [ST_W-1:0] out_status_reg, out_status_next;
    logic mem_rd_ok_reg, mem_rd_ok_next;
    logic mem_rd_chk_reg, mem_rd_chk_next;
    logic [WORD_BITS-1:0] mem_rd_reg;
    logic [ADDR_W-1:0] head_rd_reg;

    logic in_accept;
    logic emit_fire;
    logic chk_fire;
    logic more;
    logic bad;
    logic size_ok;
    logic [CMP_W-1:0] sz_c;
    logic [CMP_W-1:0] ad_c;
    logic [STEP_W-1:0] entry;
    logic [STEP_W-1:0] entry_step;
    logic [EW-1:0] eff_addr;
    logic eff_in_range;
    logic [AW-1:0] mem_idx;
    logic mem_wr_en;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_data;
    logic [HW-1:0] head_idx;
    logic head_wr_en;
    logic [ADDR_W-1:0] head_wdata;
    logic [SIZE_W-1:0] size_m1;

    assign ctrl = segfl_pkg::ucode(upc_reg);
    assign in_stall = (upc_reg != segfl_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign emit_fire = ctrl.emit && !(out_valid_reg && out_stall);
    assign mem_data = mem_rd_ok_reg ? mem_rd_reg : '0;
    assign chk_fire = mem_rd_chk_reg && (mem_data != '0);
    assign more = (({1'b0, cnt_reg} + (SIZE_W + 1)'(1)) < {1'b0, size_reg});
    assign size_m1 = size_reg - SIZE_W'(1);

    always_comb
    begin
        sz_c = CMP_W'(size);
        ad_c = CMP_W'(address);
        size_ok = (size != '0) && (sz_c <= MAX_SIZE_C);
        case (opcode)
            segfl_pkg::OP_FREE:
            begin
                bad = !size_ok || (address == '0) || ((ad_c + sz_c) > MEM_LIM_C);
                entry = segfl_pkg::S_F0;
            end
            segfl_pkg::OP_ALLOC:
            begin
                bad = !size_ok;
                entry = segfl_pkg::S_A0;
            end
            segfl_pkg::OP_WRITE:
            begin
                bad = (ad_c >= MEM_LIM_C);
                entry = segfl_pkg::S_W0;
            end
            segfl_pkg::OP_READ:
            begin
                bad = (ad_c >= MEM_LIM_C);
                entry = segfl_pkg::S_R0;
            end
            default:
            begin
                bad = 1'b1;
                entry = segfl_pkg::S_END;
            end
        endcase
        entry_step = bad ? segfl_pkg::S_END : entry;
    end

    always_comb
    begin
        case (ctrl.asrc)
            segfl_pkg::AS_BLK:     eff_addr = EW'(blk_reg);
            segfl_pkg::AS_BLK_CNT: eff_addr = EW'(blk_reg) + EW'(cnt_reg);
            segfl_pkg::AS_CLR:     eff_addr = EW'(clr_reg);
            default:               eff_addr = EW'(blk_reg);
        endcase
        eff_in_range = (eff_addr < MEM_LIM_E);
        mem_idx = eff_addr[AW-1:0];
        mem_wr_en = ctrl.mem_we && eff_in_range;
        case (ctrl.wsrc)
            segfl_pkg::WS_ZERO:  mem_wdata = '0;
            segfl_pkg::WS_WDATA: mem_wdata = WORD_BITS'(wdata_reg);
            segfl_pkg::WS_LINK:  mem_wdata = WORD_BITS'(head_rd_reg);
            default:             mem_wdata = '0;
        endcase
        if (ctrl.asrc == segfl_pkg::AS_CLR)
        begin
            head_idx = HW'(clr_reg);
            head_wr_en = ctrl.head_we && ({1'b0, clr_reg} < CLR_HEADS);
        end
        else
        begin
            head_idx = HW'(size_m1);
            head_wr_en = ctrl.head_we;
        end
        case (ctrl.hsrc)
            segfl_pkg::HS_ZERO: head_wdata = '0;
            segfl_pkg::HS_BLK:  head_wdata = blk_reg;
            segfl_pkg::HS_LINK: head_wdata = ADDR_W'(mem_data);
            default:            head_wdata = '0;
        endcase
    end

    always_comb
    begin
        upc_next = upc_reg;
        case (ctrl.cond)
            segfl_pkg::C_NEXT:
                upc_next = upc_reg + STEP_W'(1);
            segfl_pkg::C_JUMP:
                upc_next = ctrl.target;
            segfl_pkg::C_IF_MORE:
                upc_next = more ? ctrl.target : upc_reg + STEP_W'(1);
            segfl_pkg::C_IF_LAST:
                upc_next = !more ? ctrl.target : upc_reg + STEP_W'(1);
            segfl_pkg::C_IF_HEAD0:
                upc_next = (head_rd_reg == '0) ? ctrl.target : upc_reg + STEP_W'(1);
            segfl_pkg::C_IF_CLR:
                upc_next = (clr_reg != CLR_LAST) ? ctrl.target : upc_reg + STEP_W'(1);
            segfl_pkg::C_ACCEPT:
                upc_next = in_accept ? entry_step : upc_reg;
            segfl_pkg::C_EMIT:
                upc_next = emit_fire ? ctrl.target : upc_reg;
            default:
                upc_next = segfl_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next = ctrl.clr_inc ? clr_reg + CLRW'(1) : clr_reg;
        cnt_next = in_accept ? '0 : (ctrl.cnt_inc ? cnt_reg + SIZE_W'(1) : cnt_reg);
        blk_next = in_accept ? address : (ctrl.blk_ld ? head_rd_reg : blk_reg);
        size_next = in_accept ? size : size_reg;
        wdata_next = in_accept ? write_data : wdata_reg;
        if (in_accept)
        begin
            status_next = bad ? segfl_pkg::ST_BAD : segfl_pkg::ST_OK;
        end
        else
        begin
            status_next = chk_fire ? segfl_pkg::ST_UAF : status_reg;
        end
        hit_next = in_accept ? 1'b0 : (ctrl.set_hit ? 1'b1 : hit_reg);
        rdata_next = in_accept ? '0 : (ctrl.rd_ld ? DATA_W'(mem_data) : rdata_reg);
        mem_rd_ok_next = ctrl.mem_re ? eff_in_range : mem_rd_ok_reg;
        mem_rd_chk_next = ctrl.mem_re && ctrl.chk;
        out_valid_next = emit_fire ? 1'b1 : (out_valid_reg && out_stall);
        out_addr_next = out_addr_reg;
        out_hit_next = out_hit_reg;
        out_data_next = out_data_reg;
        out_status_next = out_status_reg;
        if (emit_fire)
        begin
            out_addr_next = hit_reg ? blk_reg : '0;
            out_hit_next = hit_reg;
            out_data_next = rdata_reg;
            out_status_next = status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= segfl_pkg::S_CLR;
            clr_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            mem_rd_ok_reg <= 1'b0;
            mem_rd_chk_reg <= 1'b0;
        end
        else
        begin
            upc_reg <= upc_next;
            clr_reg <= clr_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
            mem_rd_ok_reg <= mem_rd_ok_next;
            mem_rd_chk_reg <= mem_rd_chk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        size_reg <= size_next;
        wdata_reg <= wdata_next;
        status_reg <= status_next;
        hit_reg <= hit_next;
        rdata_reg <= rdata_next;
        out_addr_reg <= out_addr_next;
        out_hit_reg <= out_hit_next;
        out_data_reg <= out_data_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_idx] <= mem_wdata;
        end
        if (ctrl.mem_re)
        begin
            mem_rd_reg <= mem[mem_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_wr_en)
        begin
            head_mem[head_idx] <= head_wdata;
        end
        if (ctrl.head_re)
        begin
            head_rd_reg <= head_mem[head_idx];
        end
    end

    assign out_valid = out_valid_reg;
    assign result_address = out_addr_reg;
    assign hit = out_hit_reg;
    assign read_data = out_data_reg;
    assign status = out_status_reg;

`ifndef ASSERT_OFF
    a_check_loop_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == segfl_pkg::S_A4) |-> (cnt_reg != '0 && cnt_reg < size_reg))
        else $error("check loop offset outside the block");

    a_link_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (upc_reg == segfl_pkg::S_F1) |-> ($past(upc_reg) == segfl_pkg::S_F0))
        else $error("link write without clearing the block first");

    a_hit_block_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && hit_reg) |-> (blk_reg != '0))
        else $error("hit reported for the empty-list mark");

    a_uaf_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && status_reg == segfl_pkg::ST_UAF) |-> hit_reg)
        else $error("use-after-free flagged without a popped block");

    a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (upc_reg == segfl_pkg::S_IDLE))
        else $error("sequencer did not return to idle after a result beat");
`endif

endmodule
